/* hw/rtl/ppc_pkg.sv */
// shared constants, types and arithmetic helpers for the point covariance projection unit
package ppc_pkg;

    localparam int FW   = 32;   // input field width, Q16.16
    localparam int OW   = 64;   // result width, Q48.16
    localparam int RW   = 16;   // rotation element, Q2.14
    localparam int ROWW = 48;   // packed rotation row
    localparam int FOCW = 16;   // focal length, Q12.4
    localparam int CIW  = 3;    // config index width

    localparam int PRW  = 48;   // rotation times field product
    localparam int SUMW = 54;   // accumulator ahead of the Q2.14 rounding
    localparam int PCW  = 36;   // camera point and first rotation pass
    localparam int TPW  = 52;   // second rotation pass product
    localparam int CCW  = 40;   // rotated covariance

    localparam int DNW       = 52;  // divider numerator and quotient width
    localparam int DDW       = 36;  // divider denominator width
    localparam int DIV_LANES = 4;
    localparam int LANE_TX   = 0;
    localparam int LANE_TY   = 1;
    localparam int LANE_JU   = 2;
    localparam int LANE_JV   = 3;
    localparam int TX_SHIFT  = 17;  // Q.16 scale plus the doubling for rounding
    localparam int FOC_SHIFT = 29;  // 2^28 scale plus the doubling for rounding

    localparam int MUL_LAT = 3;
    localparam int MUL_SH  = 16;
    localparam int NMUL    = 18;

    // register stage at which each value is available
    localparam int ST_PREP  = 4;
    localparam int ST_CC    = 5;
    localparam int ST_DIV   = ST_PREP + DNW;
    localparam int ST_FIX   = ST_DIV + 1;
    localparam int ST_J     = ST_FIX + MUL_LAT;
    localparam int ST_M     = ST_J + MUL_LAT + 1;
    localparam int ST_OUT   = ST_M + MUL_LAT + 1;
    localparam int PIPE_LAT = ST_OUT;

    localparam logic [ROWW-1:0] ROT0_RST = 48'd16384;
    localparam logic [ROWW-1:0] ROT1_RST = 48'd1073741824;
    localparam logic [ROWW-1:0] ROT2_RST = 48'd70368744177664;
    localparam logic [FOCW-1:0] FOC_RST  = 16'd8000;

    localparam logic signed [PCW-1:0] DEGEN_LIM = 36'sd7;
    localparam logic signed [OW-1:0]  DEGEN_OUT = 64'sd65536000000;
    localparam logic signed [OW-1:0]  S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [OW-1:0]  S64_MIN   = 64'sh8000_0000_0000_0000;

    typedef enum logic [CIW-1:0] {
        CFG_ROT0 = 3'd0,
        CFG_ROT1 = 3'd1,
        CFG_ROT2 = 3'd2,
        CFG_FX   = 3'd3,
        CFG_FY   = 3'd4
    } cfg_reg_t;

    typedef logic [2:0][ROWW-1:0]            rot_t;
    typedef logic [2:0][PCW-1:0]             pc_vec_t;
    typedef logic [8:0][CCW-1:0]             cc_mat_t;
    typedef logic [DIV_LANES-1:0][DNW-1:0]   div_lanes_t;
    typedef logic [1:0][OW-1:0]              pair_t;

    // divide by 2^14, nearest, ties away from zero
    function automatic logic signed [CCW-1:0] rnd14(input logic signed [SUMW-1:0] s);
        logic signed [SUMW-1:0] t;
        t = s + SUMW'(8192) - SUMW'(s[SUMW-1]);
        return t[SUMW-1:14];
    endfunction

    function automatic logic signed [OW-1:0] sat_add(input logic signed [OW-1:0] a,
                                                     input logic signed [OW-1:0] b);
        logic signed [OW:0] s;
        s = (OW+1)'(a) + (OW+1)'(b);
        if (s[OW] != s[OW-1]) begin
            return s[OW] ? S64_MIN : S64_MAX;
        end
        return s[OW-1:0];
    endfunction

endpackage

/* hw/rtl/ppc_rot.sv */
// input capture and the two rotation passes: camera point and R C R^T
module ppc_rot import ppc_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  rot_t                rot,
    input  logic [2:0][FW-1:0]  pnt,
    input  logic [5:0][FW-1:0]  cov,
    output pc_vec_t             pc,
    output cc_mat_t             cc
);

    logic [2:0][FW-1:0]     pnt_reg;
    logic [5:0][FW-1:0]     cov_reg;
    logic signed [RW-1:0]   r [3][3];
    logic signed [FW-1:0]   c [3][3];
    logic signed [PRW-1:0]  rp_next [3][3];
    logic signed [PRW-1:0]  rp_reg  [3][3];
    logic signed [PRW-1:0]  rc_next [3][3][3];
    logic signed [PRW-1:0]  rc_reg  [3][3][3];
    pc_vec_t                pc_next, pc_reg;
    logic signed [PCW-1:0]  t_next [3][3];
    logic signed [PCW-1:0]  t_reg  [3][3];
    logic signed [TPW-1:0]  tr_next [3][3][3];
    logic signed [TPW-1:0]  tr_reg  [3][3][3];
    cc_mat_t                cc_next, cc_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r[i][j] = $signed(rot[i][RW*j +: RW]);
            end
        end
        // covariance is used symmetrically
        c[0][0] = $signed(cov_reg[0]);
        c[0][1] = $signed(cov_reg[1]);
        c[1][0] = $signed(cov_reg[1]);
        c[0][2] = $signed(cov_reg[2]);
        c[2][0] = $signed(cov_reg[2]);
        c[1][1] = $signed(cov_reg[3]);
        c[1][2] = $signed(cov_reg[4]);
        c[2][1] = $signed(cov_reg[4]);
        c[2][2] = $signed(cov_reg[5]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rp_next[i][j] = r[i][j] * $signed(pnt_reg[j]);
                for (int k = 0; k < 3; k++) begin
                    rc_next[i][j][k] = r[i][k] * c[k][j];
                end
            end
        end
    end

    always_comb begin
        logic signed [CCW-1:0] rr;
        for (int i = 0; i < 3; i++) begin
            rr = rnd14(SUMW'(rp_reg[i][0]) + SUMW'(rp_reg[i][1]) + SUMW'(rp_reg[i][2]));
            pc_next[i] = rr[PCW-1:0];
            for (int j = 0; j < 3; j++) begin
                rr = rnd14(SUMW'(rc_reg[i][j][0]) + SUMW'(rc_reg[i][j][1])
                           + SUMW'(rc_reg[i][j][2]));
                t_next[i][j] = rr[PCW-1:0];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    tr_next[i][j][k] = t_reg[i][k] * r[j][k];
                end
                cc_next[3*i+j] = rnd14(SUMW'(tr_reg[i][j][0]) + SUMW'(tr_reg[i][j][1])
                                       + SUMW'(tr_reg[i][j][2]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pnt_reg <= pnt;
            cov_reg <= cov;
            rp_reg  <= rp_next;
            rc_reg  <= rc_next;
            pc_reg  <= pc_next;
            t_reg   <= t_next;
            tr_reg  <= tr_next;
            cc_reg  <= cc_next;
        end
    end

    assign pc = pc_reg;
    assign cc = cc_reg;

endmodule

/* hw/rtl/ppc_div.sv */
// pipelined restoring divider, one quotient bit per stage, lanes share the divisor
module ppc_div import ppc_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  div_lanes_t        num,
    input  logic [DDW-1:0]    den,
    output div_lanes_t        quo
);

    typedef logic [DIV_LANES-1:0][DDW-1:0] rem_lanes_t;

    rem_lanes_t       rem_next [DNW];
    rem_lanes_t       rem_reg  [DNW];
    div_lanes_t       nq_next  [DNW];
    div_lanes_t       nq_reg   [DNW];
    logic [DDW-1:0]   den_reg  [DNW];

    always_comb begin
        rem_lanes_t     rin;
        div_lanes_t     nin;
        logic [DDW-1:0] din;
        logic [DDW:0]   trial;
        for (int k = 0; k < DNW; k++) begin
            if (k == 0) begin
                rin = '0;
                nin = num;
                din = den;
            end else begin
                rin = rem_reg[k-1];
                nin = nq_reg[k-1];
                din = den_reg[k-1];
            end
            // numerator bits shift out the top while quotient bits shift in below
            for (int l = 0; l < DIV_LANES; l++) begin
                trial = {rin[l], nin[l][DNW-1]};
                if (trial >= {1'b0, din}) begin
                    rem_next[k][l] = DDW'(trial - {1'b0, din});
                    nq_next[k][l]  = {nin[l][DNW-2:0], 1'b1};
                end else begin
                    rem_next[k][l] = trial[DDW-1:0];
                    nq_next[k][l]  = {nin[l][DNW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DNW; k++) begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                den_reg[k] <= (k == 0) ? den : den_reg[k-1];
            end
        end
    end

    assign quo = nq_reg[DNW-1];

endmodule

/* hw/rtl/ppc_mul.sv */
// saturating Q.16 product, round to nearest with ties away from zero, three stages
module ppc_mul import ppc_pkg::*; (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [OW-1:0]  a,
    input  logic signed [OW-1:0]  b,
    output logic signed [OW-1:0]  p
);

    logic [OW-1:0]          ua, ub;
    logic [OW-1:0]          p00_next, p01_next, p10_next, p11_next;
    logic [OW-1:0]          p00_reg, p01_reg, p10_reg, p11_reg;
    logic                   neg1_reg, neg2_reg;
    logic [2*OW-1:0]        prod_next, prod_reg;
    logic [2*OW-1:0]        rnd;
    logic [2*OW-MUL_SH-1:0] q;
    logic signed [OW-1:0]   p_next, p_reg;

    always_comb begin
        ua = a[OW-1] ? OW'(-a) : OW'(a);
        ub = b[OW-1] ? OW'(-b) : OW'(b);
        p00_next = ua[31:0]  * ub[31:0];
        p01_next = ua[31:0]  * ub[63:32];
        p10_next = ua[63:32] * ub[31:0];
        p11_next = ua[63:32] * ub[63:32];
    end

    assign prod_next = (2*OW)'(p00_reg) + ((2*OW)'(p01_reg) << 32)
                     + ((2*OW)'(p10_reg) << 32) + {p11_reg, {OW{1'b0}}};

    always_comb begin
        rnd = prod_reg + ((2*OW)'(1) << (MUL_SH - 1));
        q   = rnd[2*OW-1:MUL_SH];
        if (|q[2*OW-MUL_SH-1:OW-1]) begin
            p_next = neg2_reg ? S64_MIN : S64_MAX;
        end else begin
            p_next = neg2_reg ? -$signed(q[OW-1:0]) : $signed(q[OW-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg  <= p00_next;
            p01_reg  <= p01_next;
            p10_reg  <= p10_next;
            p11_reg  <= p11_next;
            neg1_reg <= a[OW-1] ^ b[OW-1];
            prod_reg <= prod_next;
            neg2_reg <= neg1_reg;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* hw/rtl/project_point_covariance_unit.sv */
// top level: projects a map point covariance into a 2x2 image covariance
// throughput: one point per cycle; the 52-stage depth divider sets the depth
// the whole pipe holds while a finished result waits on m_ready
// synchronous active-low reset clears valid bits and restores identity rotation,
// focal lengths 500 px; no clearing pass
module project_point_covariance_unit import ppc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [FW-1:0]  s_point_x,
    input  logic signed [FW-1:0]  s_point_y,
    input  logic signed [FW-1:0]  s_point_z,
    input  logic signed [FW-1:0]  s_cov_xx,
    input  logic signed [FW-1:0]  s_cov_xy,
    input  logic signed [FW-1:0]  s_cov_xz,
    input  logic signed [FW-1:0]  s_cov_yy,
    input  logic signed [FW-1:0]  s_cov_yz,
    input  logic signed [FW-1:0]  s_cov_zz,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [OW-1:0]  m_var_u,
    output logic signed [OW-1:0]  m_cov_uv,
    output logic signed [OW-1:0]  m_var_v,
    output logic                  m_depth_degenerate,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CIW-1:0]        cfg_index,
    input  logic [ROWW-1:0]       cfg_data
);

    localparam int NEG_LEN  = ST_DIV - ST_PREP + 1;
    localparam int DEG_LEN  = ST_OUT - ST_PREP;
    localparam int CC_LEN   = ST_J - ST_CC;
    localparam int JJ_LEN   = ST_M - ST_FIX + 1;
    localparam int J2_LEN   = ST_M - ST_J;

    logic                    adv;
    logic [PIPE_LAT-1:0]     vld_reg;
    rot_t                    rot_reg;
    logic [FOCW-1:0]         fx_reg, fy_reg;

    pc_vec_t                 pc;
    cc_mat_t                 cc;

    logic signed [PCW-1:0]   z;
    logic                    zneg;
    logic [DDW-1:0]          ud, ux, uy;
    div_lanes_t              num_next, num_reg, quo;
    logic [DDW-1:0]          den_next, den_reg;
    logic [DIV_LANES-1:0]    neg_next;
    logic                    degen_next;
    logic [DIV_LANES-1:0]    neg_dly_reg [NEG_LEN];
    logic                    deg_dly_reg [DEG_LEN];
    cc_mat_t                 cc_dly_reg  [CC_LEN];

    logic [DIV_LANES-1:0]    nq;
    logic signed [OW-1:0]    qju, qjv, qtx, qty;
    pair_t                   jj_next;
    pair_t                   jj_dly_reg [JJ_LEN];
    logic signed [OW-1:0]    mju_next, mjv_next, tx_next, ty_next;
    logic signed [OW-1:0]    mju_reg, mjv_reg, tx_reg, ty_reg;
    pair_t                   j2_dly_reg [J2_LEN];

    logic [NMUL-1:0][OW-1:0] ma, mb, mp;
    logic signed [OW-1:0]    ju_j, jv_j, ju_m, jv_m, j02_m, j12_m;
    cc_mat_t                 cc_j;
    logic signed [OW-1:0]    m00_reg, m01_reg, m02_reg, m11_reg, m12_reg;
    logic signed [OW-1:0]    var_u_reg, cov_uv_reg, var_v_reg;
    logic                    degen_reg;

    // whole pipe advances unless the output holds an untaken result
    assign adv       = m_ready || !vld_reg[PIPE_LAT-1];
    assign s_ready   = adv;
    assign m_valid   = vld_reg[PIPE_LAT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rot_reg[0] <= ROT0_RST;
            rot_reg[1] <= ROT1_RST;
            rot_reg[2] <= ROT2_RST;
            fx_reg     <= FOC_RST;
            fy_reg     <= FOC_RST;
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ROT0: rot_reg[0] <= cfg_data;
                    CFG_ROT1: rot_reg[1] <= cfg_data;
                    CFG_ROT2: rot_reg[2] <= cfg_data;
                    CFG_FX:   fx_reg     <= cfg_data[FOCW-1:0];
                    CFG_FY:   fy_reg     <= cfg_data[FOCW-1:0];
                    default: ;
                endcase
            end
        end
    end

    ppc_rot u_rot (
        .aclk (aclk),
        .en   (adv),
        .rot  (rot_reg),
        .pnt  ({s_point_z, s_point_y, s_point_x}),
        .cov  ({s_cov_zz, s_cov_yz, s_cov_yy, s_cov_xz, s_cov_xy, s_cov_xx}),
        .pc   (pc),
        .cc   (cc)
    );

    // divider operands: numerator 2|n| + |z|, divisor 2|z| gives the rounded quotient
    always_comb begin
        z    = $signed(pc[2]);
        zneg = z[PCW-1];
        ud   = zneg ? DDW'(-z) : DDW'(z);
        ux   = pc[0][PCW-1] ? DDW'(-$signed(pc[0])) : DDW'(pc[0]);
        uy   = pc[1][PCW-1] ? DDW'(-$signed(pc[1])) : DDW'(pc[1]);
        num_next[LANE_TX] = (DNW'(ux) << TX_SHIFT) + DNW'(ud);
        num_next[LANE_TY] = (DNW'(uy) << TX_SHIFT) + DNW'(ud);
        num_next[LANE_JU] = (DNW'(fx_reg) << FOC_SHIFT) + DNW'(ud);
        num_next[LANE_JV] = (DNW'(fy_reg) << FOC_SHIFT) + DNW'(ud);
        den_next          = {ud[DDW-2:0], 1'b0};
        neg_next[LANE_TX] = pc[0][PCW-1] ^ zneg;
        neg_next[LANE_TY] = pc[1][PCW-1] ^ zneg;
        neg_next[LANE_JU] = zneg;
        neg_next[LANE_JV] = zneg;
        degen_next        = (z < DEGEN_LIM) && (z > -DEGEN_LIM);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg        <= num_next;
            den_reg        <= den_next;
            neg_dly_reg[0] <= neg_next;
            deg_dly_reg[0] <= degen_next;
            cc_dly_reg[0]  <= cc;
            for (int k = 1; k < NEG_LEN; k++) neg_dly_reg[k] <= neg_dly_reg[k-1];
            for (int k = 1; k < DEG_LEN; k++) deg_dly_reg[k] <= deg_dly_reg[k-1];
            for (int k = 1; k < CC_LEN; k++)  cc_dly_reg[k]  <= cc_dly_reg[k-1];
        end
    end

    ppc_div u_div (
        .aclk (aclk),
        .en   (adv),
        .num  (num_reg),
        .den  (den_reg),
        .quo  (quo)
    );

    always_comb begin
        nq  = neg_dly_reg[NEG_LEN-1];
        qju = $signed(OW'(quo[LANE_JU]));
        qjv = $signed(OW'(quo[LANE_JV]));
        qtx = $signed(OW'(quo[LANE_TX]));
        qty = $signed(OW'(quo[LANE_TY]));
        jj_next[0] = nq[LANE_JU] ? -qju : qju;
        jj_next[1] = nq[LANE_JV] ? -qjv : qjv;
        mju_next   = nq[LANE_JU] ? qju : -qju;
        mjv_next   = nq[LANE_JV] ? qjv : -qjv;
        tx_next    = nq[LANE_TX] ? -qtx : qtx;
        ty_next    = nq[LANE_TY] ? -qty : qty;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mju_reg       <= mju_next;
            mjv_reg       <= mjv_next;
            tx_reg        <= tx_next;
            ty_reg        <= ty_next;
            jj_dly_reg[0] <= jj_next;
            for (int k = 1; k < JJ_LEN; k++) jj_dly_reg[k] <= jj_dly_reg[k-1];
            j2_dly_reg[0] <= {mp[1], mp[0]};
            for (int k = 1; k < J2_LEN; k++) j2_dly_reg[k] <= j2_dly_reg[k-1];
        end
    end

    always_comb begin
        ju_j  = $signed(jj_dly_reg[ST_J-ST_FIX][0]);
        jv_j  = $signed(jj_dly_reg[ST_J-ST_FIX][1]);
        ju_m  = $signed(jj_dly_reg[JJ_LEN-1][0]);
        jv_m  = $signed(jj_dly_reg[JJ_LEN-1][1]);
        j02_m = $signed(j2_dly_reg[J2_LEN-1][0]);
        j12_m = $signed(j2_dly_reg[J2_LEN-1][1]);
        cc_j  = cc_dly_reg[CC_LEN-1];

        // jacobian depth terms
        ma[0] = mju_reg;  mb[0] = tx_reg;
        ma[1] = mjv_reg;  mb[1] = ty_reg;
        // row 0 of J C' against columns 0..2
        for (int k = 0; k < 3; k++) begin
            ma[2+2*k] = ju_j;   mb[2+2*k] = OW'($signed(cc_j[k]));
            ma[3+2*k] = mp[0];  mb[3+2*k] = OW'($signed(cc_j[6+k]));
        end
        // row 1, columns 1 and 2
        ma[8]  = jv_j;   mb[8]  = OW'($signed(cc_j[4]));
        ma[9]  = mp[1];  mb[9]  = OW'($signed(cc_j[7]));
        ma[10] = jv_j;   mb[10] = OW'($signed(cc_j[5]));
        ma[11] = mp[1];  mb[11] = OW'($signed(cc_j[8]));
        // second product against J^T
        ma[12] = m00_reg;  mb[12] = ju_m;
        ma[13] = m02_reg;  mb[13] = j02_m;
        ma[14] = m01_reg;  mb[14] = jv_m;
        ma[15] = m02_reg;  mb[15] = j12_m;
        ma[16] = m11_reg;  mb[16] = jv_m;
        ma[17] = m12_reg;  mb[17] = j12_m;
    end

    for (genvar g = 0; g < NMUL; g++) begin : g_mul
        ppc_mul u_mul (
            .aclk (aclk),
            .en   (adv),
            .a    ($signed(ma[g])),
            .b    ($signed(mb[g])),
            .p    (mp[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m00_reg    <= sat_add($signed(mp[2]), $signed(mp[3]));
            m01_reg    <= sat_add($signed(mp[4]), $signed(mp[5]));
            m02_reg    <= sat_add($signed(mp[6]), $signed(mp[7]));
            m11_reg    <= sat_add($signed(mp[8]), $signed(mp[9]));
            m12_reg    <= sat_add($signed(mp[10]), $signed(mp[11]));
            degen_reg  <= deg_dly_reg[DEG_LEN-1];
            if (deg_dly_reg[DEG_LEN-1]) begin
                var_u_reg  <= DEGEN_OUT;
                cov_uv_reg <= '0;
                var_v_reg  <= DEGEN_OUT;
            end else begin
                var_u_reg  <= sat_add($signed(mp[12]), $signed(mp[13]));
                cov_uv_reg <= sat_add($signed(mp[14]), $signed(mp[15]));
                var_v_reg  <= sat_add($signed(mp[16]), $signed(mp[17]));
            end
        end
    end

    assign m_var_u            = var_u_reg;
    assign m_cov_uv           = cov_uv_reg;
    assign m_var_v            = var_v_reg;
    assign m_depth_degenerate = degen_reg;

endmodule

/* dv/project_point_covariance_unit_tb.sv */
// self-checking testbench for the point covariance projection unit
`timescale 1ns / 1ps

module project_point_covariance_unit_tb;
    import ppc_pkg::*;

    localparam int WDOG_LIMIT = 3000;
    localparam int DRAIN_WAIT = 80;
    localparam int LONG_HOLD  = 400;
    localparam logic [CIW-1:0] CFG_UNUSED  = 3'd7;
    localparam logic [CIW-1:0] CFG_UNUSED5 = 3'd5;
    localparam logic [CIW-1:0] CFG_UNUSED6 = 3'd6;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [FW-1:0] point_in_t [0:8];

    typedef struct {
        logic signed [OW-1:0] var_u;
        logic signed [OW-1:0] cov_uv;
        logic signed [OW-1:0] var_v;
        logic                 degen;
    } image_cov_t;

    class cov_scoreboard;
        image_cov_t      pending[$];
        logic [ROWW-1:0] rot[3];
        logic [FOCW-1:0] fx, fy;
        int              errors;

        function new();
            rot[0] = ROT0_RST;
            rot[1] = ROT1_RST;
            rot[2] = ROT2_RST;
            fx = FOC_RST;
            fy = FOC_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [CIW-1:0] idx, logic [ROWW-1:0] val);
            case (idx)
                CFG_ROT0: rot[0] = val;
                CFG_ROT1: rot[1] = val;
                CFG_ROT2: rot[2] = val;
                CFG_FX:   fx = val[FOCW-1:0];
                CFG_FY:   fy = val[FOCW-1:0];
                default: ;
            endcase
        endfunction

        // round(a*b / 2^sh), ties away from zero, saturated to 64 bits
        function wide_t mul_round(wide_t a, wide_t b, int sh);
            wide_t p, mag, q;
            p = a * b;
            mag = (p < 0) ? -p : p;
            q = (mag + (wide_t'(1) <<< (sh - 1))) >>> sh;
            if (q > wide_t'(S64_MAX))
                return (p < 0) ? wide_t'(S64_MIN) : wide_t'(S64_MAX);
            return (p < 0) ? -q : q;
        endfunction

        function wide_t div_round(wide_t n, wide_t d);
            wide_t un, ud, q;
            if (d == 0) return 0;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            q = (2 * un + ud) / (2 * ud);
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function wide_t add_sat(wide_t a, wide_t b);
            wide_t s;
            s = a + b;
            if (s > wide_t'(S64_MAX)) return wide_t'(S64_MAX);
            if (s < wide_t'(S64_MIN)) return wide_t'(S64_MIN);
            return s;
        endfunction

        function image_cov_t project(point_in_t a);
            wide_t rm[3][3], pw[3], cm[3][3], pc[3], tm[3][3], cr[3][3];
            wide_t jm[2][3], mm[2][3], s, tx, ty, ju, jv, vu, cuv, vv;
            image_cov_t r;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++)
                    rm[i][j] = $signed(rot[i][16*j +: 16]);
                pw[i] = a[i];
            end
            cm[0][0] = a[3];
            cm[0][1] = a[4]; cm[1][0] = a[4];
            cm[0][2] = a[5]; cm[2][0] = a[5];
            cm[1][1] = a[6];
            cm[1][2] = a[7]; cm[2][1] = a[7];
            cm[2][2] = a[8];
            for (int i = 0; i < 3; i++) begin
                s = 0;
                for (int j = 0; j < 3; j++) s += rm[i][j] * pw[j];
                pc[i] = mul_round(s, 1, 14);
            end
            if (pc[2] > -7 && pc[2] < 7) begin
                r.var_u = DEGEN_OUT;
                r.cov_uv = 0;
                r.var_v = DEGEN_OUT;
                r.degen = 1'b1;
                return r;
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    s = 0;
                    for (int k = 0; k < 3; k++) s += rm[i][k] * cm[k][j];
                    tm[i][j] = mul_round(s, 1, 14);
                end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    s = 0;
                    for (int k = 0; k < 3; k++) s += tm[i][k] * rm[j][k];
                    cr[i][j] = mul_round(s, 1, 14);
                end
            tx = div_round(pc[0] * 65536, pc[2]);
            ty = div_round(pc[1] * 65536, pc[2]);
            ju = div_round(wide_t'(fx) * 268435456, pc[2]);
            jv = div_round(wide_t'(fy) * 268435456, pc[2]);
            jm[0][0] = ju; jm[0][1] = 0;  jm[0][2] = mul_round(-ju, tx, 16);
            jm[1][0] = 0;  jm[1][1] = jv; jm[1][2] = mul_round(-jv, ty, 16);
            for (int i = 0; i < 2; i++)
                for (int k = 0; k < 3; k++) begin
                    s = 0;
                    for (int j = 0; j < 3; j++)
                        s = add_sat(s, mul_round(jm[i][j], cr[j][k], 16));
                    mm[i][k] = s;
                end
            vu = 0; cuv = 0; vv = 0;
            for (int k = 0; k < 3; k++) begin
                vu = add_sat(vu, mul_round(mm[0][k], jm[0][k], 16));
                cuv = add_sat(cuv, mul_round(mm[0][k], jm[1][k], 16));
                vv = add_sat(vv, mul_round(mm[1][k], jm[1][k], 16));
            end
            r.var_u = vu[OW-1:0];
            r.cov_uv = cuv[OW-1:0];
            r.var_v = vv[OW-1:0];
            r.degen = 1'b0;
            return r;
        endfunction

        function void note_point(point_in_t a);
            pending = {pending, project(a)};
        endfunction

        function void check_result(image_cov_t got);
            image_cov_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result var_u=%0d cov_uv=%0d var_v=%0d degen=%0b",
                         $time, got.var_u, got.cov_uv, got.var_v, got.degen);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.var_u !== exp_r.var_u) begin
                $display("%0t: var_u expected %0d actual %0d", $time, exp_r.var_u, got.var_u);
                errors++;
            end
            if (got.cov_uv !== exp_r.cov_uv) begin
                $display("%0t: cov_uv expected %0d actual %0d",
                         $time, exp_r.cov_uv, got.cov_uv);
                errors++;
            end
            if (got.var_v !== exp_r.var_v) begin
                $display("%0t: var_v expected %0d actual %0d", $time, exp_r.var_v, got.var_v);
                errors++;
            end
            if (got.degen !== exp_r.degen) begin
                $display("%0t: depth_degenerate expected %0b actual %0b",
                         $time, exp_r.degen, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [FW-1:0] s_point_x, s_point_y, s_point_z;
    logic signed [FW-1:0] s_cov_xx, s_cov_xy, s_cov_xz, s_cov_yy, s_cov_yz, s_cov_zz;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [OW-1:0] m_var_u, m_cov_uv, m_var_v;
    logic                 m_depth_degenerate;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CIW-1:0]       cfg_index;
    logic [ROWW-1:0]      cfg_data;

    cov_scoreboard sb;
    int  rx_gap;
    bit  hold_req;
    bit  no_idle;
    int  idle_cycles;

    project_point_covariance_unit uut (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // result side: random back-pressure, one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_gap = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_result('{m_var_u, m_cov_uv, m_var_v, m_depth_degenerate});
                if (hold_req) begin
                    rx_gap = LONG_HOLD;
                    hold_req = 0;
                end else begin
                    rx_gap = no_idle ? 0 : $urandom_range(0, 5);
                end
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            m_ready <= (rx_gap == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_point(point_in_t a);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        // a preceding register write ends here
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_point_x <= a[0]; s_point_y <= a[1]; s_point_z <= a[2];
        s_cov_xx <= a[3]; s_cov_xy <= a[4]; s_cov_xz <= a[5];
        s_cov_yy <= a[6]; s_cov_yz <= a[7]; s_cov_zz <= a[8];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_point(a);
    endtask

    task automatic write_reg(logic [CIW-1:0] idx, logic [ROWW-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic logic signed [FW-1:0] rand_span();
        logic signed [FW-1:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic point_in_t rand_point();
        point_in_t a;
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            if (mode >= 8) a[i] = $urandom;
            else a[i] = rand_span();
        end
        if (mode < 6) begin
            // plausible geometry: depth well away from zero, covariance moderate
            a[2] = $urandom_range(32'h0000_8000, 32'h0100_0000);
            if ($urandom_range(0, 3) == 0) a[2] = -a[2];
        end else if (mode == 7) begin
            a[2] = $signed($urandom_range(0, 16)) - 8;
        end
        return a;
    endfunction

    function automatic logic [ROWW-1:0] rand_row();
        logic [ROWW-1:0] r;
        r = ROWW'({$urandom, $urandom});
        for (int j = 0; j < 3; j++)
            if ($urandom_range(0, 1)) r[16*j +: 16] = $signed(r[16*j +: 16]) >>> 2;
        return r;
    endfunction

    function automatic point_in_t mk(logic signed [FW-1:0] x, logic signed [FW-1:0] y,
                                     logic signed [FW-1:0] z, logic signed [FW-1:0] c);
        point_in_t a;
        a[0] = x; a[1] = y; a[2] = z;
        for (int i = 3; i < 9; i++) a[i] = c;
        return a;
    endfunction

    initial begin
        point_in_t a;
        logic signed [FW-1:0] smax, smin;
        smax = 32'sh7FFF_FFFF;
        smin = 32'sh8000_0000;
        sb = new();
        hold_req = 0;
        no_idle = 0;
        idle_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_point_x = '0; s_point_y = '0; s_point_z = '0;
        s_cov_xx = '0; s_cov_xy = '0; s_cov_xz = '0;
        s_cov_yy = '0; s_cov_yz = '0; s_cov_zz = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: depth near the degenerate threshold, field extremes
        send_point(mk(32'sh10000, 32'sh10000, 0, 32'sh10000));
        send_point(mk(32'sh10000, 32'sh10000, 6, 32'sh10000));
        send_point(mk(32'sh10000, 32'sh10000, -6, 32'sh10000));
        send_point(mk(32'sh10000, 32'sh10000, 7, 32'sh10000));
        send_point(mk(32'sh10000, 32'sh10000, -7, 32'sh10000));
        send_point(mk(32'sh10000, -32'sh20000, 32'sh50000, 32'sh100));
        send_point(mk(smax, smax, smax, smax));
        send_point(mk(smin, smin, smin, smin));
        send_point(mk(smax, smin, 7, smax));
        send_point(mk(smin, smax, -7, smin));
        send_point(mk(smax, smax, 32'sh10000, smax));
        send_point(mk(0, 0, 32'sh10000, 0));
        send_point(mk(32'sh1234, 32'sh5678, smin, smax));
        send_point(mk(-1, -1, -1, -1));
        a = mk(32'sh30000, 32'sh18000, 32'sh40000, 32'sh0);
        a[3] = 32'sh20000; a[6] = 32'sh8000; a[8] = 32'sh1000; a[5] = -32'sh4000;
        send_point(a);
        drain();

        // extreme settings for a few directed points
        write_reg(CFG_ROT0, 48'h7FFF_7FFF_7FFF);
        write_reg(CFG_ROT1, 48'h8000_8000_8000);
        write_reg(CFG_ROT2, 48'h7FFF_8000_7FFF);
        write_reg(CFG_FX, 48'hFFFF);
        write_reg(CFG_FY, 48'h0);
        write_reg(CFG_UNUSED, 48'h1234_5678_9ABC);
        send_point(mk(smax, smax, smax, smax));
        send_point(mk(smin, smin, smin, smin));
        send_point(mk(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000));
        send_point(mk(smax, smin, smax, smin));
        send_point(mk(0, 0, 3, 32'sh10000));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_ROT0, ROT0_RST);
                    write_reg(CFG_ROT1, ROT1_RST);
                    write_reg(CFG_ROT2, ROT2_RST);
                    write_reg(CFG_FX, ROWW'(FOC_RST));
                    write_reg(CFG_FY, ROWW'(FOC_RST));
                    hold_req = 1;
                end
                1: begin
                    write_reg(CFG_ROT0, rand_row());
                    write_reg(CFG_ROT1, rand_row());
                    write_reg(CFG_ROT2, rand_row());
                    write_reg(CFG_FX, ROWW'($urandom_range(0, 65535)));
                    write_reg(CFG_FY, ROWW'($urandom_range(0, 65535)));
                end
                2: begin
                    write_reg(CFG_ROT0, 48'h8000_8000_8000);
                    write_reg(CFG_ROT1, 48'h7FFF_7FFF_7FFF);
                    write_reg(CFG_ROT2, 48'h8000_7FFF_8000);
                    write_reg(CFG_FX, 48'h0);
                    write_reg(CFG_FY, 48'hFFFF);
                    write_reg(CFG_UNUSED5, ROWW'({$urandom, $urandom}));
                    no_idle = 1;
                end
                default: begin
                    write_reg(CFG_ROT0, rand_row());
                    write_reg(CFG_ROT1, rand_row());
                    write_reg(CFG_ROT2, rand_row());
                    write_reg(CFG_FX, ROWW'($urandom_range(0, 65535)));
                    write_reg(CFG_FY, ROWW'($urandom_range(0, 65535)));
                    write_reg(CFG_UNUSED6, ROWW'({$urandom, $urandom}));
                end
            endcase
            for (int n = 0; n < 200; n++) begin
                if (phase == 2 && n == 100) no_idle = 0;
                send_point(rand_point());
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
